// ===== rtl/cfsp_pkg.sv =====
// Shared codes and sideband type for the cube face select and project block.
package cfsp_pkg;

  localparam int AXIS_BITS = 2;
  localparam int FACE_BITS = 3;

  localparam logic [AXIS_BITS-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_BITS-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_BITS-1:0] AXIS_Z = 2'd2;

  localparam logic [FACE_BITS-1:0] FACE_POS_X = 3'd0;

  // Per-word control that rides alongside the divider lanes.
  typedef struct packed {
    logic [FACE_BITS-1:0] face;
    logic                 zero;
    logic                 neg_u;
    logic                 neg_v;
  } cfsp_side_t;

endpackage

// ===== rtl/cfsp_ifs.sv =====
// Valid/ready channel interfaces for direction words in and face/coordinate words out.
interface cfsp_in_if #(
  parameter int COMPONENT_BITS = 16
);
  logic                             valid;
  logic                             ready;
  logic signed [COMPONENT_BITS-1:0] dir_x;
  logic signed [COMPONENT_BITS-1:0] dir_y;
  logic signed [COMPONENT_BITS-1:0] dir_z;

  modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
  modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

interface cfsp_out_if #(
  parameter int OUT_FRACTION_BITS = 14
);
  logic                                valid;
  logic                                ready;
  logic [cfsp_pkg::FACE_BITS-1:0]      face;
  logic signed [OUT_FRACTION_BITS+1:0] coord_u;
  logic signed [OUT_FRACTION_BITS+1:0] coord_v;
  logic                                zero_vector;

  modport source (output valid, output face, output coord_u, output coord_v,
                  output zero_vector, input ready);
  modport sink   (input valid, input face, input coord_u, input coord_v,
                  input zero_vector, output ready);
endinterface

// ===== rtl/cube_face_select_project_core.sv =====
// Top level of the cube-map face select and project block.
// Takes one signed direction word per cycle while the output is not stalled and
// returns the major face (0 +x, 1 -x, 2 +y, 3 -y, 4 +z, 5 -z) with u and v in signed
// fixed point carrying OUT_FRACTION_BITS fraction bits, rounded to nearest with
// halves away from zero; u is negated on negative faces and an all-zero direction
// returns face 0, u = v = 0 with zero_vector set. Throughput is one word per clock
// while the output is not stalled. A word passes one front stage for magnitudes
// and axis choice, a row of OUT_FRACTION_BITS + 1 division cells that each settle
// one quotient bit for both coordinates, and one output register. Every stage
// advances on its own, so a stalled output only blocks input once every stage is full.
module cube_face_select_project_core #(
  parameter int COMPONENT_BITS    = 16,
  parameter int OUT_FRACTION_BITS = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  cfsp_in_if.sink     in_dir,
  cfsp_out_if.source  out_res
);
  localparam int CB     = COMPONENT_BITS;
  localparam int RW     = COMPONENT_BITS + OUT_FRACTION_BITS;
  localparam int QW     = OUT_FRACTION_BITS + 1;
  localparam int NCELLS = OUT_FRACTION_BITS + 1;

  logic                 valid_s [0:NCELLS];
  logic                 ready_s [0:NCELLS];
  cfsp_pkg::cfsp_side_t side_s  [0:NCELLS];
  logic [CB-1:0]        div_s   [0:NCELLS];
  logic [RW-1:0]        rem_u_s [0:NCELLS];
  logic [RW-1:0]        rem_v_s [0:NCELLS];
  logic [QW-1:0]        quo_u_s [0:NCELLS];
  logic [QW-1:0]        quo_v_s [0:NCELLS];

  cfsp_prep #(
    .COMPONENT_BITS    (COMPONENT_BITS),
    .OUT_FRACTION_BITS (OUT_FRACTION_BITS)
  ) u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_dir  (in_dir),
    .valid_o (valid_s[0]),
    .ready_i (ready_s[0]),
    .side_o  (side_s[0]),
    .div_o   (div_s[0]),
    .rem_u_o (rem_u_s[0]),
    .rem_v_o (rem_v_s[0])
  );

  assign quo_u_s[0] = '0;
  assign quo_v_s[0] = '0;

  // Cell k settles quotient bit OUT_FRACTION_BITS - k, MSB first.
  for (genvar k = 0; k < NCELLS; k++) begin : g_cell
    cfsp_div_cell #(
      .DIV_BITS (CB),
      .REM_BITS (RW),
      .QUO_BITS (QW),
      .BIT_POS  (OUT_FRACTION_BITS - k)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (valid_s[k]),
      .ready_o (ready_s[k]),
      .side_i  (side_s[k]),
      .div_i   (div_s[k]),
      .rem_u_i (rem_u_s[k]),
      .rem_v_i (rem_v_s[k]),
      .quo_u_i (quo_u_s[k]),
      .quo_v_i (quo_v_s[k]),
      .valid_o (valid_s[k+1]),
      .ready_i (ready_s[k+1]),
      .side_o  (side_s[k+1]),
      .div_o   (div_s[k+1]),
      .rem_u_o (rem_u_s[k+1]),
      .rem_v_o (rem_v_s[k+1]),
      .quo_u_o (quo_u_s[k+1]),
      .quo_v_o (quo_v_s[k+1])
    );
  end

  cfsp_finish #(
    .OUT_FRACTION_BITS (OUT_FRACTION_BITS)
  ) u_finish (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (valid_s[NCELLS]),
    .ready_o (ready_s[NCELLS]),
    .side_i  (side_s[NCELLS]),
    .quo_u_i (quo_u_s[NCELLS]),
    .quo_v_i (quo_v_s[NCELLS]),
    .out_res (out_res)
  );

endmodule

// ===== rtl/cfsp_prep.sv =====
// Front stage: magnitudes, major axis, face, and the rounded dividends for both lanes.
module cfsp_prep #(
  parameter int COMPONENT_BITS    = 16,
  parameter int OUT_FRACTION_BITS = 14
) (
  input  logic                  clk,
  input  logic                  rst_n,
  cfsp_in_if.sink               in_dir,
  output logic                  valid_o,
  input  logic                  ready_i,
  output cfsp_pkg::cfsp_side_t  side_o,
  output logic [COMPONENT_BITS-1:0]                   div_o,
  output logic [COMPONENT_BITS+OUT_FRACTION_BITS-1:0] rem_u_o,
  output logic [COMPONENT_BITS+OUT_FRACTION_BITS-1:0] rem_v_o
);
  localparam int CB = COMPONENT_BITS;
  localparam int RW = COMPONENT_BITS + OUT_FRACTION_BITS;

  logic                 neg_x, neg_y, neg_z;
  logic [CB-1:0]        mag_x, mag_y, mag_z;
  logic [cfsp_pkg::AXIS_BITS-1:0] axis;
  logic [CB-1:0]        major, minor_u, minor_v;
  logic                 neg_major, neg_mu, neg_mv;
  cfsp_pkg::cfsp_side_t side_nxt;
  logic [RW-1:0]        rem_u_nxt, rem_v_nxt;

  logic                 valid_r;
  cfsp_pkg::cfsp_side_t side_r;
  logic [CB-1:0]        div_r;
  logic [RW-1:0]        rem_u_r, rem_v_r;

  assign neg_x = in_dir.dir_x[CB-1];
  assign neg_y = in_dir.dir_y[CB-1];
  assign neg_z = in_dir.dir_z[CB-1];
  // The most negative value maps to 2^(CB-1), which still fits unsigned.
  assign mag_x = neg_x ? CB'(-in_dir.dir_x) : CB'(in_dir.dir_x);
  assign mag_y = neg_y ? CB'(-in_dir.dir_y) : CB'(in_dir.dir_y);
  assign mag_z = neg_z ? CB'(-in_dir.dir_z) : CB'(in_dir.dir_z);

  // Ties go to x, then y.
  always_comb begin
    priority if (mag_x >= mag_y) begin
      axis = (mag_x >= mag_z) ? cfsp_pkg::AXIS_X : cfsp_pkg::AXIS_Z;
    end else begin
      axis = (mag_y >= mag_z) ? cfsp_pkg::AXIS_Y : cfsp_pkg::AXIS_Z;
    end
  end

  always_comb begin
    unique case (axis)
      cfsp_pkg::AXIS_X: begin
        major = mag_x; neg_major = neg_x;
        minor_u = mag_y; neg_mu = neg_y;
        minor_v = mag_z; neg_mv = neg_z;
      end
      cfsp_pkg::AXIS_Y: begin
        major = mag_y; neg_major = neg_y;
        minor_u = mag_x; neg_mu = neg_x;
        minor_v = mag_z; neg_mv = neg_z;
      end
      default: begin
        major = mag_z; neg_major = neg_z;
        minor_u = mag_x; neg_mu = neg_x;
        minor_v = mag_y; neg_mv = neg_y;
      end
    endcase
  end

  always_comb begin
    side_nxt.face  = {axis, neg_major};
    side_nxt.zero  = (major == '0);
    side_nxt.neg_u = neg_mu ^ neg_major;
    side_nxt.neg_v = neg_mv;
  end

  // Dividend carries half the divisor so the quotient rounds to nearest.
  assign rem_u_nxt = (RW'(minor_u) << OUT_FRACTION_BITS) + RW'(major >> 1);
  assign rem_v_nxt = (RW'(minor_v) << OUT_FRACTION_BITS) + RW'(major >> 1);

  assign in_dir.ready = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_dir.ready) begin
      valid_r <= in_dir.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_dir.ready && in_dir.valid) begin
      side_r  <= side_nxt;
      div_r   <= major;
      rem_u_r <= rem_u_nxt;
      rem_v_r <= rem_v_nxt;
    end
  end

  assign valid_o = valid_r;
  assign side_o  = side_r;
  assign div_o   = div_r;
  assign rem_u_o = rem_u_r;
  assign rem_v_o = rem_v_r;

endmodule

// ===== rtl/cfsp_div_cell.sv =====
// One restoring-division cell: resolves a single quotient bit for the u and v lanes.
module cfsp_div_cell #(
  parameter int DIV_BITS = 16,
  parameter int REM_BITS = 30,
  parameter int QUO_BITS = 15,
  parameter int BIT_POS  = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  cfsp_pkg::cfsp_side_t side_i,
  input  logic [DIV_BITS-1:0]  div_i,
  input  logic [REM_BITS-1:0]  rem_u_i,
  input  logic [REM_BITS-1:0]  rem_v_i,
  input  logic [QUO_BITS-1:0]  quo_u_i,
  input  logic [QUO_BITS-1:0]  quo_v_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output cfsp_pkg::cfsp_side_t side_o,
  output logic [DIV_BITS-1:0]  div_o,
  output logic [REM_BITS-1:0]  rem_u_o,
  output logic [REM_BITS-1:0]  rem_v_o,
  output logic [QUO_BITS-1:0]  quo_u_o,
  output logic [QUO_BITS-1:0]  quo_v_o
);
  logic [REM_BITS-1:0] div_sh;
  logic                ge_u, ge_v;

  logic                 valid_r;
  cfsp_pkg::cfsp_side_t side_r;
  logic [DIV_BITS-1:0]  div_r;
  logic [REM_BITS-1:0]  rem_u_r, rem_v_r;
  logic [QUO_BITS-1:0]  quo_u_r, quo_v_r;

  assign div_sh = REM_BITS'(div_i) << BIT_POS;
  assign ge_u   = (rem_u_i >= div_sh);
  assign ge_v   = (rem_v_i >= div_sh);

  // Advance when this slot is empty or its word moves on this cycle.
  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      side_r  <= side_i;
      div_r   <= div_i;
      rem_u_r <= ge_u ? (rem_u_i - div_sh) : rem_u_i;
      rem_v_r <= ge_v ? (rem_v_i - div_sh) : rem_v_i;
      quo_u_r <= quo_u_i | (QUO_BITS'(ge_u) << BIT_POS);
      quo_v_r <= quo_v_i | (QUO_BITS'(ge_v) << BIT_POS);
    end
  end

  assign valid_o = valid_r;
  assign side_o  = side_r;
  assign div_o   = div_r;
  assign rem_u_o = rem_u_r;
  assign rem_v_o = rem_v_r;
  assign quo_u_o = quo_u_r;
  assign quo_v_o = quo_v_r;

endmodule

// ===== rtl/cfsp_finish.sv =====
// Output stage: applies coordinate signs, forces the zero-vector word, holds the result.
module cfsp_finish #(
  parameter int OUT_FRACTION_BITS = 14
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  cfsp_pkg::cfsp_side_t         side_i,
  input  logic [OUT_FRACTION_BITS:0]   quo_u_i,
  input  logic [OUT_FRACTION_BITS:0]   quo_v_i,
  cfsp_out_if.source                   out_res
);
  localparam int CW = OUT_FRACTION_BITS + 2;

  logic [CW-1:0] mag_u, mag_v, coord_u_nxt, coord_v_nxt;
  logic [cfsp_pkg::FACE_BITS-1:0] face_nxt;

  logic          valid_r;
  logic [cfsp_pkg::FACE_BITS-1:0] face_r;
  logic [CW-1:0] coord_u_r, coord_v_r;
  logic          zero_r;

  assign mag_u = CW'(quo_u_i);
  assign mag_v = CW'(quo_v_i);

  always_comb begin
    if (side_i.zero) begin
      face_nxt    = cfsp_pkg::FACE_POS_X;
      coord_u_nxt = '0;
      coord_v_nxt = '0;
    end else begin
      face_nxt    = side_i.face;
      coord_u_nxt = side_i.neg_u ? (~mag_u + CW'(1)) : mag_u;
      coord_v_nxt = side_i.neg_v ? (~mag_v + CW'(1)) : mag_v;
    end
  end

  assign ready_o = !valid_r || out_res.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      face_r    <= face_nxt;
      coord_u_r <= coord_u_nxt;
      coord_v_r <= coord_v_nxt;
      zero_r    <= side_i.zero;
    end
  end

  assign out_res.valid       = valid_r;
  assign out_res.face        = face_r;
  assign out_res.coord_u     = coord_u_r;
  assign out_res.coord_v     = coord_v_r;
  assign out_res.zero_vector = zero_r;

endmodule
